// ===== sv/tile_map_render_lookup_assert.svh =====
// Assertion macros for the tile map render lookup block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TILE_MAP_RENDER_LOOKUP_ASSERT_SVH
`define TILE_MAP_RENDER_LOOKUP_ASSERT_SVH

// Condition in the same cycle.
`define TMRL_ASSERT_HOLDS(label, pre, post) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tile map lookup: same-cycle check failed");

// Condition in the following cycle.
`define TMRL_ASSERT_NEXT(label, pre, post) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tile map lookup: next-cycle check failed");

`endif

// ===== sv/tmrl_pkg.sv =====
// Package for the tile map render lookup block: field widths, register map,
// function codes and parameter defaults. No dependencies.
package tmrl_pkg;

    localparam int MAP_COLS_MAX_DEF = 64;
    localparam int MAP_ROWS_MAX_DEF = 64;
    localparam int TYPE_BITS_DEF    = 11;

    localparam int CELL_W  = 6;
    localparam int TYPE_W  = 11;
    localparam int COORD_W = 18;
    localparam int SCOL_W  = 7;
    localparam int TILE_W  = 9;
    localparam int MAPD_W  = 7;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 88;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [COORD_W-1:0] COORD_MAX = 18'h3FFFF;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        REG_SHEET_COLUMNS = 3'd0,
        REG_TILE_WIDTH    = 3'd1,
        REG_TILE_HEIGHT   = 3'd2,
        REG_MAP_WIDTH     = 3'd3,
        REG_MAP_HEIGHT    = 3'd4
    } reg_idx_t;

    localparam logic [SCOL_W-1:0] SHEET_COLUMNS_RST = 7'd16;
    localparam logic [TILE_W-1:0] TILE_WIDTH_RST    = 9'd16;
    localparam logic [TILE_W-1:0] TILE_HEIGHT_RST   = 9'd16;
    localparam logic [MAPD_W-1:0] MAP_WIDTH_RST     = 7'd64;
    localparam logic [MAPD_W-1:0] MAP_HEIGHT_RST    = 7'd64;

endpackage

// ===== sv/tile_map_render_lookup.sv =====
// Tile map render lookup: tile store, iterative divider and shared multiplier.
// Depends on tmrl_pkg and on the macros in tile_map_render_lookup_assert.svh.
`include "tile_map_render_lookup_assert.svh"

// Usage
// Input beats arrive on s_tvalid/s_tready; s_tuser is the function (0 writes
// new_type into cell (cell_x, cell_y), 1 looks the cell up). Every beat gives
// exactly one result beat on m_tvalid/m_tready, with m_tuser set when the
// cell lies outside the configured map (store untouched, type -1, zeros).
// The user must write registers over the APB port only while the block is
// idle; the block itself does not enforce this. An item in the map passes
// through the idle state in which its beat is taken, the store access, the
// restoring divider (skipped for an empty cell), the shared multiplier that
// forms the four coordinates one after another, and the load of the output
// register; a cell outside the map goes from idle straight to that load. One
// item is worked on at a time; the next beat is taken as soon as the result
// sits in the output register, even while the receiver stalls. A result that
// finds the output register still full waits until m_tready frees it.
// After reset the store is swept to -1, one entry per cycle, with s_tready
// low; APB writes still work.
module tile_map_render_lookup #(
    parameter int MAP_COLS_MAX = tmrl_pkg::MAP_COLS_MAX_DEF,
    parameter int MAP_ROWS_MAX = tmrl_pkg::MAP_ROWS_MAX_DEF,
    parameter int TYPE_BITS    = tmrl_pkg::TYPE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: cell_x[5:0], cell_y[11:6], new_type[22:12], zero[23].
    input  logic [tmrl_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: func[0].
    input  logic                            s_tuser,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: type_found[10:0], visible[11], source_x[29:12], source_y[47:30],
    // dest_x[65:48], dest_y[83:66], zero[87:84].
    output logic [tmrl_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tuser: out_of_map[0].
    output logic                            m_tuser,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmrl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tmrl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tmrl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int DEPTH = MAP_COLS_MAX * MAP_ROWS_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QB    = TYPE_BITS - 1;
    localparam int DCW   = (QB > 1) ? $clog2(QB) : 1;
    localparam int EXT_W = (TYPE_BITS > tmrl_pkg::TYPE_W) ? TYPE_BITS : tmrl_pkg::TYPE_W;
    localparam int MA    = (QB > tmrl_pkg::SCOL_W) ? QB : tmrl_pkg::SCOL_W;
    localparam int PW    = MA + tmrl_pkg::TILE_W;
    localparam int SW    = (PW > tmrl_pkg::COORD_W) ? PW : tmrl_pkg::COORD_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [tmrl_pkg::SCOL_W-1:0] sheet_columns_reg;
    logic [tmrl_pkg::TILE_W-1:0] tile_width_reg;
    logic [tmrl_pkg::TILE_W-1:0] tile_height_reg;
    logic [tmrl_pkg::MAPD_W-1:0] map_width_reg;
    logic [tmrl_pkg::MAPD_W-1:0] map_height_reg;

    // Item registers.
    logic                         func_reg;
    logic [tmrl_pkg::CELL_W-1:0]  x_reg;
    logic [tmrl_pkg::CELL_W-1:0]  y_reg;
    logic [TYPE_BITS-1:0]         t_reg;
    logic                         vis_reg;
    logic                         oom_reg;
    logic [AW-1:0]                clr_addr_reg;

    // Divider and multiplier registers.
    logic [tmrl_pkg::SCOL_W-1:0]  rem_reg;
    logic [QB-1:0]                quo_reg;
    logic [DCW-1:0]               div_cnt_reg;
    logic [2:0]                   mul_step_reg;
    logic [PW-1:0]                prod_reg;
    logic [tmrl_pkg::COORD_W-1:0] src_x_reg;
    logic [tmrl_pkg::COORD_W-1:0] src_y_reg;
    logic [tmrl_pkg::COORD_W-1:0] dst_x_reg;
    logic [tmrl_pkg::COORD_W-1:0] dst_y_reg;

    // Output registers.
    logic                              m_tvalid_reg;
    logic [tmrl_pkg::OUT_DATA_W-1:0]   m_tdata_reg;
    logic                              m_tuser_reg;

    // Tile store.
    logic [TYPE_BITS-1:0] mem [DEPTH];
    logic [TYPE_BITS-1:0] rd_data_reg;

    logic                             in_fire;
    logic [tmrl_pkg::CELL_W-1:0]      in_cell_x;
    logic [tmrl_pkg::CELL_W-1:0]      in_cell_y;
    logic signed [tmrl_pkg::TYPE_W-1:0] in_new_type;
    logic signed [EXT_W-1:0]          in_type_ext;
    logic [TYPE_BITS-1:0]             in_type_fit;
    logic                             in_outside;
    logic [AW-1:0]                    in_idx;

    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic [TYPE_BITS-1:0]             mem_wdata;

    logic [TYPE_BITS-1:0]             load_type;
    logic [tmrl_pkg::SCOL_W-1:0]      div_cols;
    logic [tmrl_pkg::SCOL_W:0]        div_shift;
    logic                             div_bit;
    logic [tmrl_pkg::SCOL_W-1:0]      rem_next;
    logic [QB-1:0]                    quo_next;

    logic [MA-1:0]                    mul_a;
    logic [tmrl_pkg::TILE_W-1:0]      mul_b;
    logic [PW-1:0]                    prod_next;
    logic [SW-1:0]                    prod_ext;
    logic [tmrl_pkg::COORD_W-1:0]     prod_sat;

    logic signed [TYPE_BITS-1:0]      t_signed;
    logic signed [EXT_W-1:0]          t_ext;
    logic                             out_free;
    logic                             fin_load;
    logic                             cfg_write;
    tmrl_pkg::reg_idx_t               cfg_idx;

    // Input decode.
    assign in_fire     = s_tvalid && s_tready;
    assign in_cell_x   = s_tdata[5:0];
    assign in_cell_y   = s_tdata[11:6];
    assign in_new_type = s_tdata[22:12];
    assign in_type_ext = in_new_type;
    assign in_type_fit = in_type_ext[TYPE_BITS-1:0];
    assign in_outside  = ({1'b0, in_cell_x} >= map_width_reg) ||
                         (32'(in_cell_x) >= MAP_COLS_MAX) ||
                         ({1'b0, in_cell_y} >= map_height_reg) ||
                         (32'(in_cell_y) >= MAP_ROWS_MAX);
    assign in_idx      = AW'(32'(in_cell_y) * MAP_COLS_MAX + 32'(in_cell_x));

    assign s_tready = (state_reg == ST_IDLE);

    // Store write port: the clearing sweep or a write item inside the map.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '1;
        end
        else
        begin
            mem_we    = in_fire && !in_outside && (s_tuser == tmrl_pkg::FUNC_WRITE);
            mem_waddr = in_idx;
            mem_wdata = in_type_fit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire)
        begin
            rd_data_reg <= mem[in_idx];
        end
    end

    // A write item reports what it stored; a lookup reports the read data.
    assign load_type = (func_reg == tmrl_pkg::FUNC_LOOKUP) ? rd_data_reg : t_reg;

    // One restoring division step per cycle.
    assign div_cols  = (sheet_columns_reg == '0) ? tmrl_pkg::SCOL_W'(1) : sheet_columns_reg;
    assign div_shift = {rem_reg, quo_reg[QB-1]};
    assign div_bit   = (div_shift >= {1'b0, div_cols});
    assign rem_next  = div_bit ? tmrl_pkg::SCOL_W'(div_shift - {1'b0, div_cols})
                               : tmrl_pkg::SCOL_W'(div_shift);
    assign quo_next  = QB'({quo_reg, div_bit});

    // Shared multiplier: remainder, quotient, column and row in turn.
    always_comb
    begin
        case (mul_step_reg)
            3'd0:
            begin
                mul_a = vis_reg ? MA'(rem_reg) : '0;
                mul_b = tile_width_reg;
            end
            3'd1:
            begin
                mul_a = vis_reg ? MA'(quo_reg) : '0;
                mul_b = tile_height_reg;
            end
            3'd2:
            begin
                mul_a = MA'(x_reg);
                mul_b = tile_width_reg;
            end
            3'd3:
            begin
                mul_a = MA'(y_reg);
                mul_b = tile_height_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);
    assign prod_ext  = SW'(prod_reg);
    assign prod_sat  = (prod_ext > SW'(tmrl_pkg::COORD_MAX)) ? tmrl_pkg::COORD_MAX
                                                             : tmrl_pkg::COORD_W'(prod_ext);

    assign t_signed = t_reg;
    assign t_ext    = t_signed;
    assign out_free = !m_tvalid_reg || m_tready;
    assign fin_load = (state_reg == ST_FIN) && out_free;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = tmrl_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_addr_reg      <= '0;
            sheet_columns_reg <= tmrl_pkg::SHEET_COLUMNS_RST;
            tile_width_reg    <= tmrl_pkg::TILE_WIDTH_RST;
            tile_height_reg   <= tmrl_pkg::TILE_HEIGHT_RST;
            map_width_reg     <= tmrl_pkg::MAP_WIDTH_RST;
            map_height_reg    <= tmrl_pkg::MAP_HEIGHT_RST;
            div_cnt_reg       <= '0;
            mul_step_reg      <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_idx)
                    tmrl_pkg::REG_SHEET_COLUMNS: sheet_columns_reg <= pwdata[6:0];
                    tmrl_pkg::REG_TILE_WIDTH:    tile_width_reg    <= pwdata[8:0];
                    tmrl_pkg::REG_TILE_HEIGHT:   tile_height_reg   <= pwdata[8:0];
                    tmrl_pkg::REG_MAP_WIDTH:     map_width_reg     <= pwdata[6:0];
                    tmrl_pkg::REG_MAP_HEIGHT:    map_height_reg    <= pwdata[6:0];
                    default: ;
                endcase
            end

            // A new result may replace the one taken in the same cycle.
            if (fin_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        func_reg <= s_tuser;
                        x_reg    <= in_cell_x;
                        y_reg    <= in_cell_y;
                        t_reg    <= in_type_fit;
                        oom_reg  <= in_outside;
                        state_reg <= in_outside ? ST_FIN : ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    t_reg        <= load_type;
                    vis_reg      <= !load_type[TYPE_BITS-1];
                    quo_reg      <= load_type[QB-1:0];
                    rem_reg      <= '0;
                    div_cnt_reg  <= '0;
                    mul_step_reg <= '0;
                    state_reg    <= load_type[TYPE_BITS-1] ? ST_MUL : ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg     <= rem_next;
                    quo_reg     <= quo_next;
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                    if (div_cnt_reg == DCW'(QB - 1))
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    // Product of step k is registered, then saturated at step k+1.
                    prod_reg     <= prod_next;
                    mul_step_reg <= mul_step_reg + 3'd1;
                    case (mul_step_reg)
                        3'd1: src_x_reg <= prod_sat;
                        3'd2: src_y_reg <= prod_sat;
                        3'd3: dst_x_reg <= prod_sat;
                        3'd4: dst_y_reg <= prod_sat;
                        default: ;
                    endcase
                    if (mul_step_reg == 3'd4)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        m_tuser_reg  <= oom_reg;
                        if (oom_reg)
                        begin
                            m_tdata_reg <= {{(tmrl_pkg::OUT_DATA_W - tmrl_pkg::TYPE_W){1'b0}},
                                            {tmrl_pkg::TYPE_W{1'b1}}};
                        end
                        else
                        begin
                            m_tdata_reg <= {4'b0, dst_y_reg, dst_x_reg, src_y_reg, src_x_reg,
                                            vis_reg, t_ext[tmrl_pkg::TYPE_W-1:0]};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;

    always_comb
    begin
        case (cfg_idx)
            tmrl_pkg::REG_SHEET_COLUMNS: prdata = 32'(sheet_columns_reg);
            tmrl_pkg::REG_TILE_WIDTH:    prdata = 32'(tile_width_reg);
            tmrl_pkg::REG_TILE_HEIGHT:   prdata = 32'(tile_height_reg);
            tmrl_pkg::REG_MAP_WIDTH:     prdata = 32'(map_width_reg);
            tmrl_pkg::REG_MAP_HEIGHT:    prdata = 32'(map_height_reg);
            default:                     prdata = '0;
        endcase
    end

    // The partial remainder never reaches the divisor.
    `TMRL_ASSERT_HOLDS(a_div_rem_below_cols, state_reg == ST_DIV, rem_reg < div_cols)
    // An accepted beat always leaves idle before the next one can be taken.
    `TMRL_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_reg != ST_IDLE)
    // A cell outside the map reports no tile and zero coordinates.
    `TMRL_ASSERT_HOLDS(a_outside_result, m_tvalid && m_tuser, m_tdata == 88'h7FF)
    // An empty cell inside the map has no sprite sheet origin.
    `TMRL_ASSERT_HOLDS(a_empty_no_source, m_tvalid && !m_tuser && !m_tdata[11], m_tdata[47:12] == '0)

endmodule
